>>> rtl/core/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types and constants for the free-page bitmap allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

  // Bitmap size in bytes, eight pages per byte
  localparam int unsigned MapBytesDflt = 512;

  // Bitmap memory word: 32 pages, lowest page in the MSB
  localparam int unsigned WordW     = 32;
  localparam int unsigned BitIdxW   = 5;

  // Pages held in use from reset on
  localparam int unsigned ReservedPages = 10;

  // Stream payload layout
  localparam int unsigned ModeW     = 2;
  localparam int unsigned PageNumW  = 16;
  localparam int unsigned AllocW    = 12;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned InDataW   = 24;
  localparam int unsigned OutDataW  = 16;

  typedef enum logic [ModeW-1:0] {
    MODE_CHECK = 2'd0,
    MODE_USE   = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_ALLOC = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

endpackage

>>> rtl/core/fpba_map_ram.sv
// ----------------------------------------------------------------------------
// fpba_map_ram
// Single-port-write, single-port-read bitmap memory, registered read data.
// ----------------------------------------------------------------------------
module fpba_map_ram #(
  parameter int unsigned Depth = 128,
  parameter int unsigned AddrW = 7
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [AddrW-1:0]              wr_addr_i,
  input  logic [fpba_pkg::WordW-1:0]    wr_data_i,
  input  logic                          rd_en_i,
  input  logic [AddrW-1:0]              rd_addr_i,
  output logic [fpba_pkg::WordW-1:0]    rd_data_o
);

  logic [fpba_pkg::WordW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

>>> rtl/core/free_page_bitmap_allocator.sv
// Check and mark read their word at acceptance, evaluate it and register the result
// word; an out-of-range page registers its result word at acceptance. Allocate reads
// word 0 at acceptance, then scans one 32-page memory read per cycle up to the first
// word with a free page or the last word. One word at a time: a new word is taken once
// the previous result is registered and the result slot is free or draining. Reset: an
// init sweep writes the start-up bitmap, one memory word per cycle, with tready held low.
// ----------------------------------------------------------------------------
// free_page_bitmap_allocator
// Free-page bitmap with check, mark used, mark free and first-fit allocate.
// ----------------------------------------------------------------------------
module free_page_bitmap_allocator #(
  parameter int unsigned MAP_BYTES = fpba_pkg::MapBytesDflt
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tdata: mode[1:0], page_num[17:2], zero[23:18]
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [fpba_pkg::InDataW-1:0]   s_axis_tdata,
  // tdata: free_bit[0], alloc_page[12:1], status[14:13], zero[15]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [fpba_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int unsigned Words = (MAP_BYTES + 3) / 4;
  localparam int unsigned AddrW = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned Pages = MAP_BYTES * 8;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Words - 1);

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EVAL
  } state_e;

  state_e                              state_q;
  fpba_pkg::mode_e                     mode_q;
  logic [fpba_pkg::BitIdxW-1:0]        bitsel_q;
  logic [AddrW-1:0]                    addr_q;
  logic [AddrW-1:0]                    init_addr_q;
  logic                                out_valid_q;
  logic                                out_free_q;
  logic [fpba_pkg::AllocW-1:0]         out_alloc_q;
  fpba_pkg::status_e                   out_status_q;

  fpba_pkg::mode_e                     in_mode;
  logic [fpba_pkg::PageNumW-1:0]       in_page;
  logic [10:0]                         in_word;
  logic                                in_range;
  logic                                accept;

  logic                                wr_en;
  logic [AddrW-1:0]                    wr_addr;
  logic [fpba_pkg::WordW-1:0]          wr_data;
  logic                                rd_en;
  logic [AddrW-1:0]                    rd_addr;
  logic [fpba_pkg::WordW-1:0]          rd_data;

  logic [fpba_pkg::WordW-1:0]          init_word;
  logic [31:0]                         init_page;
  logic                                found;
  logic [fpba_pkg::BitIdxW-1:0]        found_idx;
  logic [AddrW+fpba_pkg::BitIdxW-1:0]  found_page;
  logic [31:0]                         found_ext;
  logic [fpba_pkg::WordW-1:0]          mark_mask;
  logic [fpba_pkg::WordW-1:0]          grant_mask;

  assign in_mode  = fpba_pkg::mode_e'(s_axis_tdata[1:0]);
  assign in_page  = s_axis_tdata[17:2];
  assign in_word  = in_page[15:5];
  assign in_range = 32'(in_page) < Pages;

  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Start-up contents: pages below the reserved count and past the end are used
  always_comb begin
    init_word = '0;
    init_page = '0;
    for (int b = 0; b < 32; b++) begin
      init_page = (32'(init_addr_q) << 5) | 32'(31 - b);
      init_word[b] = (init_page >= fpba_pkg::ReservedPages) && (init_page < Pages);
    end
  end

  // First free page in the word: highest set bit
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = 0; i < 32; i++) begin
      if (rd_data[i]) begin
        found     = 1'b1;
        found_idx = fpba_pkg::BitIdxW'(31 - i);
      end
    end
  end

  assign found_page = {addr_q, found_idx};
  assign found_ext  = 32'(found_page);
  assign mark_mask  = fpba_pkg::WordW'(1) << bitsel_q;
  assign grant_mask = fpba_pkg::WordW'(1) << (~found_idx);

  // Memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_q;
    wr_data = rd_data;
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state_q)
      ST_INIT: begin
        wr_en   = 1'b1;
        wr_addr = init_addr_q;
        wr_data = init_word;
      end
      ST_IDLE: begin
        rd_en   = accept;
        rd_addr = (in_mode == fpba_pkg::MODE_ALLOC) ? '0 : in_word[AddrW-1:0];
      end
      ST_EVAL: begin
        unique case (mode_q)
          fpba_pkg::MODE_USE: begin
            wr_en   = 1'b1;
            wr_data = rd_data & ~mark_mask;
          end
          fpba_pkg::MODE_FREE: begin
            wr_en   = 1'b1;
            wr_data = rd_data | mark_mask;
          end
          fpba_pkg::MODE_ALLOC: begin
            wr_en   = found;
            wr_data = rd_data & ~grant_mask;
            // advance the scan one word per cycle
            rd_en   = !found && (addr_q != LastAddr);
            rd_addr = addr_q + AddrW'(1);
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      mode_q       <= fpba_pkg::MODE_CHECK;
      bitsel_q     <= '0;
      addr_q       <= '0;
      init_addr_q  <= '0;
      out_valid_q  <= 1'b0;
      out_free_q   <= 1'b0;
      out_alloc_q  <= '0;
      out_status_q <= fpba_pkg::STATUS_OK;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_INIT: begin
          init_addr_q <= init_addr_q + AddrW'(1);
          if (init_addr_q == LastAddr) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            mode_q   <= in_mode;
            bitsel_q <= ~in_page[4:0];
            addr_q   <= (in_mode == fpba_pkg::MODE_ALLOC) ? '0 : in_word[AddrW-1:0];
            if (in_mode != fpba_pkg::MODE_ALLOC && !in_range) begin
              out_valid_q  <= 1'b1;
              out_free_q   <= 1'b0;
              out_alloc_q  <= '0;
              out_status_q <= fpba_pkg::STATUS_RANGE;
            end else begin
              state_q <= ST_EVAL;
            end
          end
        end
        ST_EVAL: begin
          if (mode_q == fpba_pkg::MODE_ALLOC) begin
            if (found) begin
              out_valid_q  <= 1'b1;
              out_free_q   <= 1'b0;
              out_alloc_q  <= found_ext[fpba_pkg::AllocW-1:0];
              out_status_q <= fpba_pkg::STATUS_OK;
              state_q      <= ST_IDLE;
            end else if (addr_q == LastAddr) begin
              out_valid_q  <= 1'b1;
              out_free_q   <= 1'b0;
              out_alloc_q  <= '0;
              out_status_q <= fpba_pkg::STATUS_FULL;
              state_q      <= ST_IDLE;
            end else begin
              addr_q <= addr_q + AddrW'(1);
            end
          end else begin
            out_valid_q  <= 1'b1;
            out_free_q   <= rd_data[bitsel_q];
            out_alloc_q  <= '0;
            out_status_q <= fpba_pkg::STATUS_OK;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_INIT;
        end
      endcase
    end
  end

  fpba_map_ram #(
    .Depth (Words),
    .AddrW (AddrW)
  ) u_map_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_status_q, out_alloc_q, out_free_q};

endmodule

>>> rtl/core/fpba_checker.sv
// ----------------------------------------------------------------------------
// fpba_checker
// Port-level checks for the free-page bitmap allocator, bound to the top.
// ----------------------------------------------------------------------------
module fpba_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [fpba_pkg::OutDataW-1:0]  m_axis_tdata
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // A new word is taken only when the result slot is free or draining
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
    else $error("input accepted while a result word is stalled");

  // Status code is always a defined one
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[14:13] == fpba_pkg::STATUS_OK) ||
      (m_axis_tdata[14:13] == fpba_pkg::STATUS_RANGE) ||
      (m_axis_tdata[14:13] == fpba_pkg::STATUS_FULL))
    else $error("undefined status code");

  // Error results carry no page and no free bit
  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[14:13] != fpba_pkg::STATUS_OK) |->
      (m_axis_tdata[12:0] == 13'd0))
    else $error("error result with nonzero payload");

endmodule

bind free_page_bitmap_allocator fpba_checker u_fpba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the free-page bitmap allocator. A queue of requests
// feeds a clocked stream driver that runs a bit-per-page shadow bitmap on every
// accepted word and logs the expected reply. A clocked monitor compares each
// reply with the oldest logged one. Stimulus: corner requests, a random mix,
// then a burst of first-fit allocations with no idling.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned MapBytes   = fpba_pkg::MapBytesDflt;
  localparam int unsigned PageCount  = MapBytes * 8;
  localparam int unsigned ScanCycles = MapBytes / 4 + 2;
  // longest quiet stretch: full scan plus a gap on both sides, taken four times over
  localparam int unsigned StallLimit = 4 * (ScanCycles + 2 * 18 + 8);
  localparam int unsigned RandomReqs = 560;
  localparam int unsigned AllocBurst = 100;

  typedef struct packed {
    logic [fpba_pkg::PageNumW-1:0] page;
    fpba_pkg::mode_e               mode;
  } page_req_t;

  typedef struct packed {
    logic                        free_bit;
    logic [fpba_pkg::AllocW-1:0] alloc_page;
    fpba_pkg::status_e           status;
  } page_reply_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [fpba_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [fpba_pkg::OutDataW-1:0] m_axis_tdata;

  page_req_t   pending_reqs[$];
  page_reply_t expected_replies[$];
  logic        free_pages[PageCount];
  page_req_t   req_on_bus;

  bit          idle_en = 1'b1;
  int unsigned send_gap, recv_gap, quiet_cycles;
  int unsigned fail_count, words_sent, words_checked;
  int unsigned grants_seen, full_seen, range_seen;

  free_page_bitmap_allocator #(
    .MAP_BYTES(MapBytes)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Update the shadow bitmap for one request and return the reply it causes.
  function automatic page_reply_t apply_page_op(page_req_t r);
    page_reply_t rep;
    rep = '{free_bit: 1'b0, alloc_page: '0, status: fpba_pkg::STATUS_OK};
    if (r.mode == fpba_pkg::MODE_ALLOC) begin
      rep.status = fpba_pkg::STATUS_FULL;
      for (int unsigned p = 0; p < PageCount; p++) begin
        if (free_pages[p]) begin
          free_pages[p]  = 1'b0;
          rep.alloc_page = p[fpba_pkg::AllocW-1:0];
          rep.status     = fpba_pkg::STATUS_OK;
          break;
        end
      end
    end else if (r.page >= PageCount) begin
      rep.status = fpba_pkg::STATUS_RANGE;
    end else begin
      rep.free_bit = free_pages[r.page];
      if (r.mode == fpba_pkg::MODE_USE) free_pages[r.page] = 1'b0;
      else if (r.mode == fpba_pkg::MODE_FREE) free_pages[r.page] = 1'b1;
    end
    return rep;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic add_req(input fpba_pkg::mode_e mode, input int unsigned page);
    pending_reqs.push_back('{page: page[fpba_pkg::PageNumW-1:0], mode: mode});
  endtask

  // Hold until every queued word is sent and every reply is back.
  task automatic wait_drained;
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_replies.size() != 0);
  endtask

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      send_gap      = 0;
      for (int unsigned p = 0; p < PageCount; p++) begin
        free_pages[p] = (p >= fpba_pkg::ReservedPages);
      end
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_replies.push_back(apply_page_op(req_on_bus));
        words_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (idle_en && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 18) - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          req_on_bus = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'b0, req_on_bus.page, req_on_bus.mode};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Reply monitor
  always @(posedge clk_i or negedge rst_ni) begin
    page_reply_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap      = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.free_bit   = m_axis_tdata[0];
        got.alloc_page = m_axis_tdata[12:1];
        got.status     = fpba_pkg::status_e'(m_axis_tdata[14:13]);
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("reply word 0x%04h with nothing outstanding", m_axis_tdata));
        end else begin
          want = expected_replies.pop_front();
          words_checked++;
          if (got.free_bit !== want.free_bit)
            report_mismatch($sformatf("free_bit expected %0d got %0b",
                                      want.free_bit, got.free_bit));
          if (got.alloc_page !== want.alloc_page)
            report_mismatch($sformatf("alloc_page expected %0d got %0d",
                                      want.alloc_page, got.alloc_page));
          if (got.status !== want.status)
            report_mismatch($sformatf("status expected %s got %0d",
                                      want.status.name(), m_axis_tdata[14:13]));
          if (want.status == fpba_pkg::STATUS_FULL) full_seen++;
          else if (want.status == fpba_pkg::STATUS_RANGE) range_seen++;
          else grants_seen++;
        end
      end
      if (recv_gap != 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(1, 18) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("tb: timeout after %0d quiet cycles", quiet_cycles);
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned pg;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corners: reserved pages, edges of the map, out-of-range pages,
    // marking twice, first fit picking up a freed low page
    add_req(fpba_pkg::MODE_CHECK, 0);
    add_req(fpba_pkg::MODE_CHECK, fpba_pkg::ReservedPages - 1);
    add_req(fpba_pkg::MODE_CHECK, fpba_pkg::ReservedPages);
    add_req(fpba_pkg::MODE_CHECK, PageCount - 1);
    add_req(fpba_pkg::MODE_CHECK, PageCount);
    add_req(fpba_pkg::MODE_CHECK, 16'hFFFF);
    add_req(fpba_pkg::MODE_USE, PageCount);
    add_req(fpba_pkg::MODE_FREE, 16'hFFFF);
    add_req(fpba_pkg::MODE_USE, 16'h8000);
    add_req(fpba_pkg::MODE_ALLOC, 16'hFFFF);
    add_req(fpba_pkg::MODE_ALLOC, 0);
    add_req(fpba_pkg::MODE_USE, 12);
    add_req(fpba_pkg::MODE_USE, 12);
    add_req(fpba_pkg::MODE_FREE, 5);
    add_req(fpba_pkg::MODE_FREE, 5);
    add_req(fpba_pkg::MODE_ALLOC, 16'h5555);
    add_req(fpba_pkg::MODE_CHECK, 12);
    add_req(fpba_pkg::MODE_FREE, 0);
    add_req(fpba_pkg::MODE_ALLOC, 16'hAAAA);
    add_req(fpba_pkg::MODE_USE, PageCount - 1);
    add_req(fpba_pkg::MODE_CHECK, PageCount - 1);
    add_req(fpba_pkg::MODE_FREE, PageCount - 1);
    add_req(fpba_pkg::MODE_ALLOC, 0);
    wait_drained();

    // random mix, leaning on low pages so allocate and mark collide
    for (int unsigned i = 0; i < RandomReqs; i++) begin
      case ($urandom_range(0, 3))
        0:       pg = $urandom_range(0, 16'hFFFF);
        1:       pg = $urandom_range(0, PageCount - 1);
        default: pg = $urandom_range(0, 255);
      endcase
      add_req(fpba_pkg::mode_e'($urandom_range(0, 3)), pg);
    end
    wait_drained();

    // back-to-back first-fit allocations, then reopen a few pages
    idle_en = 1'b0;
    repeat (AllocBurst) add_req(fpba_pkg::MODE_ALLOC, $urandom_range(0, 16'hFFFF));
    add_req(fpba_pkg::MODE_CHECK, $urandom_range(0, PageCount - 1));
    add_req(fpba_pkg::MODE_CHECK, $urandom_range(PageCount, 16'hFFFF));
    repeat (3) add_req(fpba_pkg::MODE_FREE, $urandom_range(0, PageCount - 1));
    repeat (4) add_req(fpba_pkg::MODE_ALLOC, 0);
    add_req(fpba_pkg::MODE_CHECK, PageCount - 1);
    wait_drained();
    repeat (ScanCycles + 8) @(posedge clk_i);

    $display("tb: %0d request words sent, %0d replies checked", words_sent, words_checked);
    $display("tb: %0d ok replies, %0d out-of-range, %0d map-full", grants_seen,
             range_seen, full_seen);
    if (fail_count == 0 && expected_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
